// ===== src/pcp_pkg.sv =====
// Shared widths, command codes and register indexes for the clamped PI controller.
// No dependencies; every other file imports this package.
package pcp_pkg;

    // Field widths fixed by the interface
    localparam int GAIN_W    = 24;                  // Q8.16 gain as stored
    localparam int GAIN_X_W  = GAIN_W + 1;          // gain after negation
    localparam int LIMIT_W   = 16;                  // drive limits, scale, drive
    localparam int LEVEL_W   = 16;                  // measured, target, preload level
    localparam int ERR_W     = LEVEL_W + 1;         // error and serial multiplier operand
    localparam int INTEG_W   = 32;                  // integral, Q16.16, never negative
    localparam int FRAC_W    = 16;

    // Serial multiplier operands
    localparam int MCAND_W   = 34;                  // gains, preload level, first preload product
    localparam int MPLIER_W  = ERR_W;               // error, drive_max, preload_scale
    localparam int PROD_W    = MCAND_W + MPLIER_W;
    localparam int SUM_W     = PROD_W + 1;          // product plus integral

    localparam int DIGIT_W_DEF = 4;

    // APB register file
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEG_GAIN    = 3'd1,
        REG_DRIVE_MIN     = 3'd2,
        REG_DRIVE_MAX     = 3'd3,
        REG_REVERSE       = 3'd4,
        REG_PRELOAD_SCALE = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_COMPUTE = 2'd0,
        CMD_PRELOAD = 2'd1,
        CMD_CLEAR   = 2'd2
    } cmd_t;

    // Reset values of the registers
    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = 24'd65536;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST    = 24'd0;
    localparam logic [LIMIT_W-1:0] DRIVE_MIN_RST     = 16'd0;
    localparam logic [LIMIT_W-1:0] DRIVE_MAX_RST     = 16'hFFFF;
    localparam logic [LIMIT_W-1:0] PRELOAD_SCALE_RST = 16'd2621;

endpackage

// ===== src/pcp_mul.sv =====
// Digit-serial signed multiplier: one multiplier digit per cycle, shift-right accumulate.
// Depends on pcp_pkg for operand widths. DIGIT_W may range from 1 to 8.
module pcp_mul
    import pcp_pkg::*;
#(
    parameter int DIGIT_W = DIGIT_W_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [MCAND_W-1:0]  mcand,
    input  logic signed [MPLIER_W-1:0] mplier,
    output logic                       busy,
    output logic signed [PROD_W-1:0]   prod
);

    localparam int NDIG  = (MPLIER_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W = NDIG * DIGIT_W;
    localparam int H_W   = MCAND_W + DIGIT_W + 1;
    localparam int CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    logic signed [MCAND_W-1:0] mcand_reg;
    logic [PAD_W-1:0]          mplier_reg;
    logic signed [H_W-1:0]     hi_reg;
    logic [PAD_W-1:0]          lo_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      busy_reg;

    logic [DIGIT_W-1:0]        digit;
    logic signed [H_W-1:0]     mcand_ext;
    logic signed [H_W-1:0]     digit_ext;
    logic signed [H_W-1:0]     sum;
    logic signed [PAD_W-1:0]   mplier_ext;
    logic [H_W+PAD_W-1:0]      full;

    assign digit      = mplier_reg[DIGIT_W-1:0];
    assign mcand_ext  = H_W'(mcand_reg);
    // the top digit carries the sign of the multiplier
    assign digit_ext  = (cnt_reg == '0) ? H_W'($signed(digit))
                                        : H_W'($signed({1'b0, digit}));
    assign sum        = hi_reg + mcand_ext * digit_ext;
    assign mplier_ext = PAD_W'(mplier);
    assign full       = {hi_reg, lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NDIG - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            mplier_reg <= mplier_ext;
            hi_reg     <= '0;
            lo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            // retire the low digit of the partial sum into the product's low half
            hi_reg     <= sum >>> DIGIT_W;
            lo_reg     <= {sum[DIGIT_W-1:0], lo_reg[PAD_W-1:DIGIT_W]};
            mplier_reg <= mplier_reg >> DIGIT_W;
        end
    end

    assign busy = busy_reg;
    assign prod = $signed(full[PROD_W-1:0]);

endmodule

// ===== src/pi_controller_clamped_preload_core.sv =====
// Top level of the clamped PI controller: APB registers, command sequencer, clamp logic.
// Depends on pcp_pkg and two pcp_mul digit-serial multipliers.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------
//  input    | in_valid / in_stall      | command, measured, target, preload_level
//  output   | out_valid / out_stall    | drive
//  config   | psel penable pwrite ...  | paddr, pwdata, prdata
//
// With D = DIGIT_W and N = ceil(17 / D) multiplier digits, the kp and ki products of a
// compute item run side by side, one digit per cycle. A preload forms its two products
// in turn, sharing one multiplier. Clear, a disarmed preload and the unused code complete
// without leaving the idle state.
// Reset restores register defaults, zeroes the integral and arms the preload.
// A result waiting on out_stall holds only the final step of the next compute item.
module pi_controller_clamped_preload_core
    import pcp_pkg::*;
#(
    parameter int DIGIT_W = DIGIT_W_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                command,
    input  logic signed [LEVEL_W-1:0] measured,
    input  logic signed [LEVEL_W-1:0] target,
    input  logic signed [LEVEL_W-1:0] preload_level,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [LIMIT_W-1:0]        drive,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRIVE,
        ST_PRE1,
        ST_PRE2
    } state_t;

    state_t               state_reg;
    logic [INTEG_W-1:0]   integral_reg;
    logic                 armed_reg;
    logic                 out_valid_reg;
    logic [LIMIT_W-1:0]   drive_reg;

    logic [GAIN_W-1:0]    prop_gain_reg;
    logic [GAIN_W-1:0]    integ_gain_reg;
    logic [LIMIT_W-1:0]   drive_min_reg;
    logic [LIMIT_W-1:0]   drive_max_reg;
    logic                 reverse_reg;
    logic [LIMIT_W-1:0]   preload_scale_reg;

    logic                 cfg_write;
    logic [IDX_W-1:0]     cfg_idx;
    logic                 in_fire;
    logic                 out_free;

    logic signed [ERR_W-1:0]    err;
    logic signed [GAIN_X_W-1:0] kp_eff;
    logic signed [GAIN_X_W-1:0] ki_eff;

    logic                       mul0_start;
    logic signed [MCAND_W-1:0]  mul0_mcand;
    logic signed [MPLIER_W-1:0] mul0_mplier;
    logic                       mul0_busy;
    logic signed [PROD_W-1:0]   mul0_prod;
    logic                       mul1_start;
    logic                       mul1_busy;
    logic signed [PROD_W-1:0]   mul1_prod;

    logic signed [SUM_W-1:0]    integ_ext;
    logic signed [SUM_W-1:0]    integ_sum;
    logic signed [SUM_W-1:0]    drive_sum;
    logic [INTEG_W-1:0]         integ_clamped;
    logic [INTEG_W-1:0]         drive_clamped;
    logic [INTEG_W-1:0]         preload_clamped;

    // Above the upper limit first, then below the lower one
    function automatic logic [INTEG_W-1:0] clamp_q16(
        input logic signed [SUM_W-1:0] v,
        input logic [LIMIT_W-1:0]      lo,
        input logic [LIMIT_W-1:0]      hi
    );
        logic signed [SUM_W-1:0] hi_s;
        logic signed [SUM_W-1:0] lo_s;
        hi_s = $signed(SUM_W'({hi, {FRAC_W{1'b0}}}));
        lo_s = $signed(SUM_W'({lo, {FRAC_W{1'b0}}}));
        priority if (v > hi_s)
        begin
            return {hi, {FRAC_W{1'b0}}};
        end
        else if (v < lo_s)
        begin
            return {lo, {FRAC_W{1'b0}}};
        end
        else
        begin
            return v[INTEG_W-1:0];
        end
    endfunction

    // ---------------------------------------------------------------- registers
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integ_gain_reg    <= INTEG_GAIN_RST;
            drive_min_reg     <= DRIVE_MIN_RST;
            drive_max_reg     <= DRIVE_MAX_RST;
            reverse_reg       <= 1'b0;
            preload_scale_reg <= PRELOAD_SCALE_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_PROP_GAIN:     prop_gain_reg     <= pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:    integ_gain_reg    <= pwdata[GAIN_W-1:0];
                REG_DRIVE_MIN:     drive_min_reg     <= pwdata[LIMIT_W-1:0];
                REG_DRIVE_MAX:     drive_max_reg     <= pwdata[LIMIT_W-1:0];
                REG_REVERSE:       reverse_reg       <= pwdata[0];
                REG_PRELOAD_SCALE: preload_scale_reg <= pwdata[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_PROP_GAIN:     prdata = DATA_W'(prop_gain_reg);
            REG_INTEG_GAIN:    prdata = DATA_W'(integ_gain_reg);
            REG_DRIVE_MIN:     prdata = DATA_W'(drive_min_reg);
            REG_DRIVE_MAX:     prdata = DATA_W'(drive_max_reg);
            REG_REVERSE:       prdata = DATA_W'(reverse_reg);
            REG_PRELOAD_SCALE: prdata = DATA_W'(preload_scale_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- operands
    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_free = !(out_valid_reg && out_stall);

    assign err    = ERR_W'(target) - ERR_W'(measured);
    assign kp_eff = reverse_reg ? -GAIN_X_W'($signed(prop_gain_reg))
                                :  GAIN_X_W'($signed(prop_gain_reg));
    assign ki_eff = reverse_reg ? -GAIN_X_W'($signed(integ_gain_reg))
                                :  GAIN_X_W'($signed(integ_gain_reg));

    always_comb
    begin
        mul0_start  = 1'b0;
        mul1_start  = 1'b0;
        mul0_mcand  = MCAND_W'(ki_eff);
        mul0_mplier = err;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command == CMD_COMPUTE)
                begin
                    mul0_start = 1'b1;
                    mul1_start = 1'b1;
                end
                else if (in_fire && command == CMD_PRELOAD && armed_reg)
                begin
                    // level times drive_max first
                    mul0_start  = 1'b1;
                    mul0_mcand  = MCAND_W'(preload_level);
                    mul0_mplier = $signed({1'b0, drive_max_reg});
                end
            end
            ST_PRE1:
            begin
                // then that product times the scale
                mul0_start  = !mul0_busy;
                mul0_mcand  = mul0_prod[MCAND_W-1:0];
                mul0_mplier = $signed({1'b0, preload_scale_reg});
            end
            default:
            begin
            end
        endcase
    end

    pcp_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul_ki (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul0_start),
        .mcand  (mul0_mcand),
        .mplier (mul0_mplier),
        .busy   (mul0_busy),
        .prod   (mul0_prod)
    );

    pcp_mul #(
        .DIGIT_W (DIGIT_W)
    ) u_mul_kp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul1_start),
        .mcand  (MCAND_W'(kp_eff)),
        .mplier (err),
        .busy   (mul1_busy),
        .prod   (mul1_prod)
    );

    assign integ_ext       = $signed(SUM_W'(integral_reg));
    assign integ_sum       = SUM_W'(mul0_prod) + integ_ext;
    assign drive_sum       = SUM_W'(mul1_prod) + integ_ext;
    assign integ_clamped   = clamp_q16(integ_sum, drive_min_reg, drive_max_reg);
    assign drive_clamped   = clamp_q16(drive_sum, drive_min_reg, drive_max_reg);
    assign preload_clamped = clamp_q16(SUM_W'(mul0_prod), drive_min_reg, drive_max_reg);

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            integral_reg  <= '0;
            armed_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
        end
        else
        begin
            // the drive step reloads the flag itself
            if (out_valid_reg && !out_stall && state_reg != ST_DRIVE)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        unique case (command)
                            CMD_COMPUTE:
                            begin
                                state_reg <= ST_MUL;
                            end
                            CMD_PRELOAD:
                            begin
                                if (armed_reg)
                                begin
                                    state_reg <= ST_PRE1;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                integral_reg <= '0;
                                armed_reg    <= 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_MUL:
                begin
                    if (!mul0_busy && !mul1_busy)
                    begin
                        integral_reg <= integ_clamped;
                        state_reg    <= ST_DRIVE;
                    end
                end
                ST_DRIVE:
                begin
                    // hold until the previous transfer is taken
                    if (out_free)
                    begin
                        drive_reg     <= drive_clamped[INTEG_W-1:FRAC_W];
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_PRE1:
                begin
                    if (!mul0_busy)
                    begin
                        state_reg <= ST_PRE2;
                    end
                end
                ST_PRE2:
                begin
                    if (!mul0_busy)
                    begin
                        integral_reg <= preload_clamped;
                        armed_reg    <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

`ifndef SYNTHESIS
    a_result_from_drive: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DRIVE))
        else $error("result raised outside the drive step");

    a_idle_mul_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mul0_busy && !mul1_busy))
        else $error("multiplier busy while sequencer idle");

    a_preload_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRE2 && !mul0_busy) |=> !armed_reg)
        else $error("preload left armed after seeding the integral");
`endif

endmodule
